### hw/rtl/phc_pkg.sv
// Shared constants, codes and types for the packet header classifier.
`timescale 1ns / 1ps

package phc_pkg;

  localparam int unsigned QUEUE_COUNT_DEF = 64;

  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_QINQ = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [4:0] L3_UNTAGGED = 5'd14;
  localparam logic [4:0] L3_TAGGED   = 5'd18;

  localparam logic [31:0] IP4_BCAST      = 32'hFFFFFFFF;
  localparam logic [31:0] IP4_MCAST_MASK = 32'hF0000000;
  localparam logic [31:0] IP4_MCAST_BASE = 32'hE0000000;
  localparam logic [7:0]  IP6_MCAST_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    RSN_NONE     = 3'd0,
    RSN_SHORT_L3 = 3'd1,
    RSN_NOT_IP   = 3'd2,
    RSN_BCAST    = 3'd3,
    RSN_NOT_L4   = 3'd4,
    RSN_IHL      = 3'd5,
    RSN_SHORT_L4 = 3'd6
  } reason_t;

  typedef struct packed {
    logic        candidate;
    reason_t     pass_reason;
    logic        is_ipv6;
    logic        is_tcp;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [5:0]  queue_out;
  } result_t;

endpackage

### hw/rtl/phc_in_if.sv
// Byte channel into the classifier: valid/ready handshake and one frame byte.
`timescale 1ns / 1ps

interface phc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;
  logic [5:0] queue_num;

  modport source (output valid, data_byte, end_of_frame, queue_num, input ready);
  modport sink   (input valid, data_byte, end_of_frame, queue_num, output ready);
endinterface

### hw/rtl/phc_out_if.sv
// Verdict channel out of the classifier: valid/ready handshake and one result.
`timescale 1ns / 1ps

interface phc_out_if;
  logic        valid;
  logic        ready;
  logic        candidate;
  logic [2:0]  pass_reason;
  logic        is_ipv6;
  logic        is_tcp;
  logic [63:0] src_addr_high;
  logic [63:0] src_addr_low;
  logic [63:0] dst_addr_high;
  logic [63:0] dst_addr_low;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [5:0]  queue_out;

  modport source (
    output valid, candidate, pass_reason, is_ipv6, is_tcp, src_addr_high, src_addr_low,
           dst_addr_high, dst_addr_low, src_port, dst_port, queue_out,
    input  ready
  );
  modport sink (
    input  valid, candidate, pass_reason, is_ipv6, is_tcp, src_addr_high, src_addr_low,
           dst_addr_high, dst_addr_low, src_port, dst_port, queue_out,
    output ready
  );
endinterface

### hw/rtl/packet_header_classifier.sv
// The verdict is registered and is on out_bus in the cycle after the final beat of a frame is taken.
// Throughput: one byte beat per cycle while in_bus.ready is high; the frame state and
//   result registers are the only storage, so a frame may follow the previous one at once.
// in_bus.ready drops only while a verdict waits in the result register and is not taken.
// Reset (rst_n low, synchronous): frame state returns to offset 0 / untagged, result
//   register empty.
`timescale 1ns / 1ps

module packet_header_classifier #(
  parameter int unsigned QUEUE_COUNT = phc_pkg::QUEUE_COUNT_DEF
) (
  input logic      clk,
  input logic      rst_n,
  phc_in_if.sink   in_bus,
  phc_out_if.source out_bus
);
  import phc_pkg::*;

  localparam logic [8:0] QUEUE_LIMIT = QUEUE_COUNT[8:0];

  // Frame state, captured byte by byte at fixed offsets.
  logic [7:0]  offset_r, offset_nxt;
  logic [15:0] ether_type_r, ether_type_nxt;
  logic [4:0]  l3_start_r, l3_start_nxt;
  logic [7:0]  ip_proto_r, ip_proto_nxt;
  logic [3:0]  header_words_r, header_words_nxt;
  logic [63:0] src_hi_r, src_hi_nxt;
  logic [63:0] src_lo_r, src_lo_nxt;
  logic [63:0] dst_hi_r, dst_hi_nxt;
  logic [63:0] dst_lo_r, dst_lo_nxt;
  logic [31:0] port_pair_r, port_pair_nxt;

  // State after the current beat is folded in, before any end-of-frame clear.
  logic [15:0] cap_etype;
  logic [4:0]  cap_l3;
  logic [7:0]  cap_proto;
  logic [3:0]  cap_hw;
  logic [63:0] cap_src_hi, cap_src_lo, cap_dst_hi, cap_dst_lo;
  logic [31:0] cap_ports;

  logic [7:0]  rel;        // offset inside the L3 header
  logic [7:0]  l4_base;    // IHL * 4, from the IHL held before this beat
  logic        port_win;

  logic [8:0]  frame_len;
  logic [8:0]  l3_len;
  logic [8:0]  l4_len;
  logic        l4_ok;
  logic        ok;
  reason_t     reason;

  result_t     res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_fire;

  logic [7:0]  b;
  assign b = in_bus.data_byte;

  // Accept a beat whenever the result slot is free or being drained this cycle.
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire      = in_bus.valid && in_bus.ready;

  assign rel      = offset_r - {3'b000, l3_start_r};
  assign l4_base  = {2'b00, header_words_r, 2'b00};

  // Fold the incoming byte into the header state.
  always_comb begin
    cap_etype  = ether_type_r;
    cap_l3     = l3_start_r;
    cap_proto  = ip_proto_r;
    cap_hw     = header_words_r;
    cap_src_hi = src_hi_r;
    cap_src_lo = src_lo_r;
    cap_dst_hi = dst_hi_r;
    cap_dst_lo = dst_lo_r;
    cap_ports  = port_pair_r;
    port_win   = (rel >= l4_base) && (rel < (l4_base + 8'd4));

    if (offset_r == 8'd12 || offset_r == 8'd13) begin
      cap_etype = {ether_type_r[7:0], b};
      // One VLAN or QinQ tag moves L3 out by four bytes.
      if (offset_r == 8'd13 && (cap_etype == ETYPE_VLAN || cap_etype == ETYPE_QINQ)) begin
        cap_l3 = L3_TAGGED;
      end
    end else if ((offset_r == 8'd16 || offset_r == 8'd17) && l3_start_r == L3_TAGGED) begin
      cap_etype = {ether_type_r[7:0], b};
    end else if (offset_r >= {3'b000, l3_start_r}) begin
      if (ether_type_r == ETYPE_IPV4) begin
        if (rel == 8'd0) begin
          cap_hw = b[3:0];
        end else if (rel == 8'd9) begin
          cap_proto = b;
        end else if (rel >= 8'd12 && rel <= 8'd15) begin
          cap_src_lo = {src_lo_r[55:0], b};
        end else if (rel >= 8'd16 && rel <= 8'd19) begin
          cap_dst_lo = {dst_lo_r[55:0], b};
        end
        // Port window uses the freshly taken IHL but the old base; the pair
        // register keeps only the last four bytes shifted in.
        if (cap_hw >= 4'd5 && port_win) begin
          cap_ports = {port_pair_r[23:0], b};
        end
      end else if (ether_type_r == ETYPE_IPV6) begin
        if (rel == 8'd6) begin
          cap_proto = b;
        end else if (rel >= 8'd8 && rel <= 8'd15) begin
          cap_src_hi = {src_hi_r[55:0], b};
        end else if (rel >= 8'd16 && rel <= 8'd23) begin
          cap_src_lo = {src_lo_r[55:0], b};
        end else if (rel >= 8'd24 && rel <= 8'd31) begin
          cap_dst_hi = {dst_hi_r[55:0], b};
        end else if (rel >= 8'd32 && rel <= 8'd39) begin
          cap_dst_lo = {dst_lo_r[55:0], b};
        end else if (rel >= 8'd40 && rel <= 8'd43) begin
          cap_ports = {port_pair_r[23:0], b};
        end
      end
    end
  end

  // Verdict on the state as it stands after the final byte; first failing check wins.
  assign frame_len = {1'b0, offset_r} + 9'd1;
  assign l3_len    = {4'b0000, cap_l3};
  assign l4_len    = (cap_proto == PROTO_TCP) ? 9'd20 : 9'd8;
  assign l4_ok     = (cap_proto == PROTO_TCP) || (cap_proto == PROTO_UDP);

  always_comb begin
    reason = RSN_NONE;
    if (frame_len < 9'd14 || frame_len < l3_len) begin
      reason = RSN_SHORT_L3;
    end else if (cap_etype == ETYPE_IPV4) begin
      if (frame_len < l3_len + 9'd20) begin
        reason = RSN_SHORT_L3;
      end else if (cap_dst_lo[31:0] == IP4_BCAST
                   || (cap_dst_lo[31:0] & IP4_MCAST_MASK) == IP4_MCAST_BASE) begin
        reason = RSN_BCAST;
      end else if (!l4_ok) begin
        reason = RSN_NOT_L4;
      end else if (cap_hw < 4'd5) begin
        reason = RSN_IHL;
      end else if (frame_len < l3_len + {3'b000, cap_hw, 2'b00} + l4_len) begin
        reason = RSN_SHORT_L4;
      end
    end else if (cap_etype == ETYPE_IPV6) begin
      if (frame_len < l3_len + 9'd40) begin
        reason = RSN_SHORT_L3;
      end else if (cap_dst_hi[63:56] == IP6_MCAST_BYTE) begin
        reason = RSN_BCAST;
      end else if (!l4_ok) begin
        reason = RSN_NOT_L4;
      end else if (frame_len < l3_len + 9'd40 + l4_len) begin
        reason = RSN_SHORT_L4;
      end
    end else begin
      reason = RSN_NOT_IP;
    end
  end

  assign ok = (reason == RSN_NONE);

  // Build the result; a failed check zeroes everything but the reason and queue.
  always_comb begin
    res_nxt               = '0;
    res_nxt.pass_reason   = reason;
    res_nxt.queue_out     = in_bus.queue_num;
    res_nxt.candidate     = ok && ({3'b000, in_bus.queue_num} < QUEUE_LIMIT);
    if (ok) begin
      res_nxt.is_ipv6  = (cap_etype == ETYPE_IPV6);
      res_nxt.is_tcp   = (cap_proto == PROTO_TCP);
      res_nxt.src_port = cap_ports[31:16];
      res_nxt.dst_port = cap_ports[15:0];
      if (cap_etype == ETYPE_IPV6) begin
        res_nxt.src_addr_high = cap_src_hi;
        res_nxt.src_addr_low  = cap_src_lo;
        res_nxt.dst_addr_high = cap_dst_hi;
        res_nxt.dst_addr_low  = cap_dst_lo;
      end else begin
        res_nxt.src_addr_low = {32'd0, cap_src_lo[31:0]};
        res_nxt.dst_addr_low = {32'd0, cap_dst_lo[31:0]};
      end
    end
  end

  // Next frame state: advance on a middle beat, drop everything on the final beat.
  always_comb begin
    offset_nxt       = offset_r;
    ether_type_nxt   = ether_type_r;
    l3_start_nxt     = l3_start_r;
    ip_proto_nxt     = ip_proto_r;
    header_words_nxt = header_words_r;
    src_hi_nxt       = src_hi_r;
    src_lo_nxt       = src_lo_r;
    dst_hi_nxt       = dst_hi_r;
    dst_lo_nxt       = dst_lo_r;
    port_pair_nxt    = port_pair_r;
    if (in_fire) begin
      if (in_bus.end_of_frame) begin
        offset_nxt       = '0;
        ether_type_nxt   = '0;
        l3_start_nxt     = L3_UNTAGGED;
        ip_proto_nxt     = '0;
        header_words_nxt = '0;
        src_hi_nxt       = '0;
        src_lo_nxt       = '0;
        dst_hi_nxt       = '0;
        dst_lo_nxt       = '0;
        port_pair_nxt    = '0;
      end else begin
        // Hold the offset at 255 on long frames.
        offset_nxt       = (offset_r == 8'd255) ? offset_r : offset_r + 8'd1;
        ether_type_nxt   = cap_etype;
        l3_start_nxt     = cap_l3;
        ip_proto_nxt     = cap_proto;
        header_words_nxt = cap_hw;
        src_hi_nxt       = cap_src_hi;
        src_lo_nxt       = cap_src_lo;
        dst_hi_nxt       = cap_dst_hi;
        dst_lo_nxt       = cap_dst_lo;
        port_pair_nxt    = cap_ports;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire && in_bus.end_of_frame) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r       <= '0;
      ether_type_r   <= '0;
      l3_start_r     <= L3_UNTAGGED;
      ip_proto_r     <= '0;
      header_words_r <= '0;
      src_hi_r       <= '0;
      src_lo_r       <= '0;
      dst_hi_r       <= '0;
      dst_lo_r       <= '0;
      port_pair_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      offset_r       <= offset_nxt;
      ether_type_r   <= ether_type_nxt;
      l3_start_r     <= l3_start_nxt;
      ip_proto_r     <= ip_proto_nxt;
      header_words_r <= header_words_nxt;
      src_hi_r       <= src_hi_nxt;
      src_lo_r       <= src_lo_nxt;
      dst_hi_r       <= dst_hi_nxt;
      dst_lo_r       <= dst_lo_nxt;
      port_pair_r    <= port_pair_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result payload: load on the final beat only.
  always_ff @(posedge clk) begin
    if (in_fire && in_bus.end_of_frame) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.candidate     = res_r.candidate;
  assign out_bus.pass_reason   = res_r.pass_reason;
  assign out_bus.is_ipv6       = res_r.is_ipv6;
  assign out_bus.is_tcp        = res_r.is_tcp;
  assign out_bus.src_addr_high = res_r.src_addr_high;
  assign out_bus.src_addr_low  = res_r.src_addr_low;
  assign out_bus.dst_addr_high = res_r.dst_addr_high;
  assign out_bus.dst_addr_low  = res_r.dst_addr_low;
  assign out_bus.src_port      = res_r.src_port;
  assign out_bus.dst_port      = res_r.dst_port;
  assign out_bus.queue_out     = res_r.queue_out;

endmodule

### hw/rtl/phc_checker.sv
// Port-level checks for the packet header classifier, bound to the top level.
`timescale 1ns / 1ps

module phc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_end_of_frame,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_candidate,
  input logic [2:0]  out_pass_reason,
  input logic        out_is_ipv6,
  input logic        out_is_tcp,
  input logic [63:0] out_src_addr_high,
  input logic [63:0] out_dst_addr_high,
  input logic [15:0] out_src_port,
  input logic [15:0] out_dst_port
);
  import phc_pkg::*;

  // A stalled verdict holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pass_reason)
      && $stable(out_candidate) && $stable(out_src_port))
    else $error("verdict changed while stalled");

  // A new verdict follows a final beat.
  a_out_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_end_of_frame))
    else $error("verdict without a final beat");

  // A failed check reports no candidate, no IPv6 or TCP flag and zero ports.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pass_reason != RSN_NONE |-> !out_candidate && !out_is_ipv6
      && !out_is_tcp && out_src_port == 16'd0 && out_dst_port == 16'd0)
    else $error("failed verdict carries captured fields");

  // IPv4 verdicts leave the upper address halves clear.
  a_ipv4_upper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_ipv6 |-> out_src_addr_high == 64'd0 && out_dst_addr_high == 64'd0)
    else $error("upper address set on a non-IPv6 verdict");

endmodule

bind packet_header_classifier phc_checker u_phc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_bus.valid),
  .in_ready          (in_bus.ready),
  .in_end_of_frame   (in_bus.end_of_frame),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_candidate     (out_bus.candidate),
  .out_pass_reason   (out_bus.pass_reason),
  .out_is_ipv6       (out_bus.is_ipv6),
  .out_is_tcp        (out_bus.is_tcp),
  .out_src_addr_high (out_bus.src_addr_high),
  .out_dst_addr_high (out_bus.dst_addr_high),
  .out_src_port      (out_bus.src_port),
  .out_dst_port      (out_bus.dst_port)
);
